@@ rtl/bll_pkg.sv @@
package bll_pkg;

   // default sizing
   localparam int POOL_DEPTH_DEF  = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // request / response field widths
   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 7;

   // request opcodes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STS_BAD_POS   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;

endpackage

@@ rtl/bll_ram.sv @@
module bll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-during-write to the same entry returns the old contents
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bounded_linked_list_engine.sv @@
// channel   ports                                        direction  handshake
// req       req_op, req_value, req_position              in         req_valid / req_stall
// rsp       rsp_status, rsp_result_value,                out        rsp_valid / rsp_stall
//           rsp_match_index, rsp_length
//
// One request is worked at a time; a new one is taken while the last
// response still sits in the output register.
// Push: decode, take a node, write it, link it behind the old tail (back
// push, non-empty list), respond. Pop front: decode, pop, respond. Insert,
// pop back and search walk one node per cycle via the registered link read port.
// reset (synchronous) empties the list and pool; no memory clearing pass.
// rsp_stall only holds the response register; the next request still runs
// up to its response step and waits there.
module bounded_linked_list_engine #(
   parameter int POOL_DEPTH  = bll_pkg::POOL_DEPTH_DEF,
   parameter int VALUE_WIDTH = bll_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic        [bll_pkg::OP_W-1:0]     req_op,
   input  logic signed [bll_pkg::DATA_W-1:0]   req_value,
   input  logic        [bll_pkg::POS_W-1:0]    req_position,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [bll_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [bll_pkg::DATA_W-1:0]   rsp_result_value,
   output logic        [bll_pkg::LEN_W-1:0]    rsp_match_index,
   output logic        [bll_pkg::LEN_W-1:0]    rsp_length
);

   import bll_pkg::*;

   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   // compare width wide enough for both position and count plus one
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [10:0] {
      S_IDLE   = 11'h001,
      S_DECODE = 11'h002,
      S_WALK   = 11'h004,
      S_TAKE   = 11'h008,
      S_TAKE_W = 11'h010,
      S_WRN    = 11'h020,
      S_WRB    = 11'h040,
      S_POPF   = 11'h080,
      S_POPB   = 11'h100,
      S_POPB2  = 11'h200,
      S_RESP   = 11'h400
   } state_type;

   // where a new node goes in the list
   typedef enum logic [1:0] {
      KIND_FRONT,
      KIND_BACK,
      KIND_MID
   } kind_type;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   // captured request
   logic [OP_W-1:0]        op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   // list and pool bookkeeping
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;

   // walk / edit working registers
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [IDX_W-1:0] next_ff, next_in;
   logic [IDX_W-1:0] node_ff, node_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   // result being built
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [VALUE_WIDTH-1:0] rv_ff, rv_in;
   logic [CNT_W-1:0]       midx_ff, midx_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]          rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]           rsp_midx_ff, rsp_midx_in;
   logic [LEN_W-1:0]           rsp_len_ff, rsp_len_in;

   // memory ports
   logic                   lnk_we;
   logic [IDX_W-1:0]       lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;
   logic                   val_we;
   logic [IDX_W-1:0]       val_waddr, val_raddr;
   logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

   logic             full;
   logic             empty;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;

   bll_ram #(
      .WIDTH (IDX_W),
      .DEPTH (POOL_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (lnk_we),
      .waddr (lnk_waddr),
      .wdata (lnk_wdata),
      .raddr (lnk_raddr),
      .rdata (lnk_rdata)
   );

   bll_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (POOL_DEPTH)
   ) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (val_wdata),
      .raddr (val_raddr),
      .rdata (val_rdata)
   );

   assign full    = (count_ff == CNT_W'(POOL_DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      next_in       = next_ff;
      node_in       = node_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      rv_in         = rv_ff;
      midx_in       = midx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_midx_in   = rsp_midx_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      lnk_we    = 1'b0;
      lnk_waddr = node_ff;
      lnk_wdata = '0;
      lnk_raddr = cur_ff;
      val_we    = 1'b0;
      val_waddr = node_ff;
      val_wdata = val_ff;
      val_raddr = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               val_in   = VALUE_WIDTH'($unsigned(req_value));
               pos_in   = req_position;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = STS_OK;
            rv_in     = '0;
            midx_in   = '0;
            state_in  = S_RESP;
            case (op_ff)
               OP_PUSH_FRONT: begin
                  if (full) begin
                     status_in = STS_FULL;
                  end else begin
                     kind_in  = KIND_FRONT;
                     state_in = S_TAKE;
                  end
               end
               OP_PUSH_BACK: begin
                  if (full) begin
                     status_in = STS_FULL;
                  end else begin
                     kind_in  = KIND_BACK;
                     prev_in  = tail_ff;
                     state_in = S_TAKE;
                  end
               end
               OP_INSERT: begin
                  if (pos_ff == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                     status_in = STS_BAD_POS;
                  end else if (full) begin
                     status_in = STS_FULL;
                  end else if (pos_ext == CMP_W'(1)) begin
                     kind_in  = KIND_FRONT;
                     state_in = S_TAKE;
                  end else if (pos_ext == cnt_ext + CMP_W'(1)) begin
                     kind_in  = KIND_BACK;
                     prev_in  = tail_ff;
                     state_in = S_TAKE;
                  end else begin
                     // walk to the node before the target position
                     kind_in   = KIND_MID;
                     rem_in    = CNT_W'(pos_ext - CMP_W'(2));
                     cur_in    = head_ff;
                     lnk_raddr = head_ff;
                     state_in  = S_WALK;
                  end
               end
               OP_POP_FRONT: begin
                  if (empty) begin
                     status_in = STS_EMPTY;
                  end else begin
                     lnk_raddr = head_ff;
                     val_raddr = head_ff;
                     state_in  = S_POPF;
                  end
               end
               OP_POP_BACK: begin
                  if (empty) begin
                     status_in = STS_EMPTY;
                  end else if (count_ff == CNT_W'(1)) begin
                     lnk_raddr = head_ff;
                     val_raddr = head_ff;
                     state_in  = S_POPF;
                  end else begin
                     // walk to the node before the tail
                     rem_in    = count_ff - CNT_W'(2);
                     cur_in    = head_ff;
                     lnk_raddr = head_ff;
                     state_in  = S_WALK;
                  end
               end
               OP_SEARCH: begin
                  if (empty) begin
                     status_in = STS_NOT_FOUND;
                  end else begin
                     idx_in    = CNT_W'(1);
                     cur_in    = head_ff;
                     lnk_raddr = head_ff;
                     val_raddr = head_ff;
                     state_in  = S_WALK;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // one node per cycle: data for cur_ff arrives, next read is issued
         // straight from the link just read
         S_WALK: begin
            if (op_ff == OP_SEARCH) begin
               if (val_rdata == val_ff) begin
                  status_in = STS_OK;
                  rv_in     = val_rdata;
                  midx_in   = idx_ff;
                  state_in  = S_RESP;
               end else if (idx_ff == count_ff) begin
                  status_in = STS_NOT_FOUND;
                  state_in  = S_RESP;
               end else begin
                  cur_in    = lnk_rdata;
                  lnk_raddr = lnk_rdata;
                  val_raddr = lnk_rdata;
                  idx_in    = idx_ff + CNT_W'(1);
               end
            end else if (rem_ff == '0) begin
               prev_in = cur_ff;
               next_in = lnk_rdata;
               if (op_ff == OP_POP_BACK) begin
                  state_in = S_POPB;
               end else begin
                  state_in = S_TAKE;
               end
            end else begin
               cur_in    = lnk_rdata;
               lnk_raddr = lnk_rdata;
               rem_in    = rem_ff - CNT_W'(1);
            end
         end

         // released nodes first, then never-used ones
         S_TAKE: begin
            if (free_count_ff != '0) begin
               node_in   = free_head_ff;
               lnk_raddr = free_head_ff;
               state_in  = S_TAKE_W;
            end else begin
               node_in  = fresh_ff[IDX_W-1:0];
               fresh_in = fresh_ff + CNT_W'(1);
               state_in = S_WRN;
            end
         end

         S_TAKE_W: begin
            free_head_in  = lnk_rdata;
            free_count_in = free_count_ff - CNT_W'(1);
            state_in      = S_WRN;
         end

         S_WRN: begin
            val_we   = 1'b1;
            lnk_we   = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
            case (kind_ff)
               KIND_FRONT: begin
                  lnk_wdata = empty ? '0 : head_ff;
                  head_in   = node_ff;
                  if (empty) begin
                     tail_in = node_ff;
                  end
               end
               KIND_BACK: begin
                  lnk_wdata = '0;
                  tail_in   = node_ff;
                  if (empty) begin
                     head_in = node_ff;
                  end else begin
                     state_in = S_WRB;
                  end
               end
               KIND_MID: begin
                  lnk_wdata = next_ff;
                  state_in  = S_WRB;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         // hook the new node behind its predecessor
         S_WRB: begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_ff;
            lnk_wdata = node_ff;
            state_in  = S_RESP;
         end

         S_POPF: begin
            rv_in         = val_rdata;
            lnk_we        = 1'b1;
            lnk_waddr     = head_ff;
            lnk_wdata     = free_head_ff;
            free_head_in  = head_ff;
            free_count_in = free_count_ff + CNT_W'(1);
            count_in      = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else begin
               head_in = lnk_rdata;
            end
            state_in = S_RESP;
         end

         // release the tail, fetch its value
         S_POPB: begin
            lnk_we        = 1'b1;
            lnk_waddr     = tail_ff;
            lnk_wdata     = free_head_ff;
            free_head_in  = tail_ff;
            free_count_in = free_count_ff + CNT_W'(1);
            val_raddr     = tail_ff;
            state_in      = S_POPB2;
         end

         S_POPB2: begin
            rv_in     = val_rdata;
            lnk_we    = 1'b1;
            lnk_waddr = prev_ff;
            lnk_wdata = '0;
            tail_in   = prev_ff;
            count_in  = count_ff - CNT_W'(1);
            state_in  = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = DATA_W'(rv_ff);
               rsp_midx_in   = LEN_W'(midx_ff);
               rsp_len_in    = LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         free_head_ff  <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      next_ff       <= next_in;
      node_ff       <= node_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      rv_ff         <= rv_in;
      midx_ff       <= midx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_midx_ff   <= rsp_midx_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = $signed(rsp_value_ff);
   assign rsp_match_index  = rsp_midx_ff;
   assign rsp_length       = rsp_len_ff;

   // list never outgrows the pool
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(POOL_DEPTH))
      else $error("list count above pool depth");

   // between requests every used node is either listed or free
   a_pool_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         ({1'b0, fresh_ff} == {1'b0, count_ff} + {1'b0, free_count_ff}))
      else $error("node pool bookkeeping out of balance");

   // an empty list has both ends parked at zero
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with stale head or tail");

   // a response only appears out of the response step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response step");

endmodule

@@ test/list_scoreboard_pkg.sv @@
`timescale 1ns / 1ps

package list_scoreboard_pkg;
   import bll_pkg::*;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic [LEN_W-1:0]         match_index;
      logic [LEN_W-1:0]         length;
   } list_rsp_type;

   class list_scoreboard;
      // list contents, front first; node placement in the pool is not visible
      logic signed [DATA_W-1:0] contents[$];
      list_rsp_type             expected_rsp[$];
      int                       errors = 0;

      function int size_now();
         return contents.size();
      endfunction

      function logic signed [DATA_W-1:0] stored_at(int i);
         return contents[i];
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         list_rsp_type r;
         int           i;
         bit           full;
         r.status      = STS_OK;
         r.value       = '0;
         r.match_index = '0;
         full = contents.size() >= POOL_DEPTH_DEF;
         case (op)
            OP_PUSH_FRONT: begin
               if (full) r.status = STS_FULL;
               else contents.push_front(value);
            end
            OP_PUSH_BACK: begin
               if (full) r.status = STS_FULL;
               else contents.push_back(value);
            end
            OP_INSERT: begin
               // position range is checked ahead of pool space
               if (pos == 0 || int'(pos) > contents.size() + 1) r.status = STS_BAD_POS;
               else if (full) r.status = STS_FULL;
               else contents.insert(int'(pos) - 1, value);
            end
            OP_POP_FRONT: begin
               if (contents.size() == 0) r.status = STS_EMPTY;
               else r.value = contents.pop_front();
            end
            OP_POP_BACK: begin
               if (contents.size() == 0) r.status = STS_EMPTY;
               else r.value = contents.pop_back();
            end
            OP_SEARCH: begin
               r.status = STS_NOT_FOUND;
               for (i = 0; i < contents.size() && r.status == STS_NOT_FOUND; i++) begin
                  if (contents[i] == value) begin
                     r.status      = STS_OK;
                     r.value       = contents[i];
                     r.match_index = LEN_W'(i + 1);
                  end
               end
            end
            default: ;
         endcase
         r.length = LEN_W'(contents.size());
         expected_rsp.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic signed [DATA_W-1:0] value,
                                   logic [LEN_W-1:0] match_index, logic [LEN_W-1:0] length);
         list_rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
         if (value !== e.value) begin
            $error("result_value: expected %0d, got %0d", e.value, value);
            errors++;
         end
         if (match_index !== e.match_index) begin
            $error("match_index: expected %0d, got %0d", e.match_index, match_index);
            errors++;
         end
         if (length !== e.length) begin
            $error("length: expected %0d, got %0d", e.length, length);
            errors++;
         end
      endfunction
   endclass

endpackage

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import bll_pkg::*;
   import list_scoreboard_pkg::*;

   // cycles with no accepted request or response before the run is abandoned;
   // worst honest gap is a full-list walk plus long random idles/stalls
   localparam int QUIET_LIMIT = 3000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 220;

   // op codes with no function; the block must ignore them
   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [OP_W-1:0]            req_op;
   logic signed [DATA_W-1:0]   req_value;
   logic [POS_W-1:0]           req_position;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0]   rsp_result_value;
   logic [LEN_W-1:0]           rsp_match_index;
   logic [LEN_W-1:0]           rsp_length;

   list_scoreboard sb = new();

   // idling knobs, percent of cycles
   int idle_pct  = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   // per-phase settings: sender idle, receiver stall, share of requests that grow the list
   int phase_idle[PHASES]  = '{0, 81, 0, 36, 0, 81, 0, 36};
   int phase_stall[PHASES] = '{0, 0, 81, 36, 0, 0, 81, 36};
   int phase_grow[PHASES]  = '{60, 85, 55, 20, 50, 30, 90, 10};

   bounded_linked_list_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_match_index  (rsp_match_index),
      .rsp_length       (rsp_length)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // receiver back-pressure, updated on the falling edge
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // response monitor: sampled at the rising edge, before the block's updates land
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_result_value, rsp_match_index, rsp_length);
   end

   // watchdog: any handshake on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request; entered and left at a falling edge. Valid is only
   // lowered on an idle cycle, so it never drops and rises in one step.
   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_value    <= value;
      req_position <= pos;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, value, pos);
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding request has its response
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // values: full-range random for bit coverage, a small set for duplicates,
   // and values already stored so searches hit
   function automatic logic signed [DATA_W-1:0] pick_value();
      int len;
      len = sb.size_now();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $signed($urandom_range(0, 7)) - 4;
         default: begin
            if (len == 0) return $urandom;
            return sb.stored_at($urandom_range(0, len - 1));
         end
      endcase
   endfunction

   task automatic random_request(input int grow_pct);
      int                       len;
      int                       r;
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      len   = sb.size_now();
      r     = $urandom_range(0, 99);
      value = pick_value();
      pos   = POS_W'($urandom);
      if (r < 5) begin
         // noise: unused op codes and out-of-range insert positions
         if ($urandom_range(0, 1) == 0) begin
            op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
         end else begin
            op  = OP_INSERT;
            pos = ($urandom_range(0, 3) == 0) ? '0 : POS_W'($urandom_range(len + 2, 127));
         end
      end else if (r < 5 + (grow_pct * 95) / 100) begin
         case ($urandom_range(0, 2))
            0: op = OP_PUSH_FRONT;
            1: op = OP_PUSH_BACK;
            default: begin
               op  = OP_INSERT;
               pos = POS_W'($urandom_range(1, len + 1));
            end
         endcase
      end else begin
         case ($urandom_range(0, 2))
            0: op = OP_POP_FRONT;
            1: op = OP_POP_BACK;
            default: op = OP_SEARCH;
         endcase
      end
      send_request(op, value, pos);
   endtask

   initial begin
      int p;
      int n;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = '0;
      req_value    = '0;
      req_position = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty-list corners, bad positions, ends, extremes, unused ops
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_SEARCH, 0, 0);
      send_request(OP_INSERT, 1, 0);              // position zero
      send_request(OP_INSERT, 2, 2);              // past end of empty list
      send_request(OP_INSERT, 5, 1);              // position 1 on empty list
      send_request(OP_SPARE_A, 32'h1234_5678, 7'd5);
      send_request(OP_SPARE_B, -1, 7'd127);
      send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF, 0);
      send_request(OP_PUSH_FRONT, 32'sh8000_0000, 0);
      send_request(OP_INSERT, 0, 4);              // length plus one: lands at tail
      send_request(OP_INSERT, -1, 3);             // true middle insert
      send_request(OP_INSERT, 9, 127);
      send_request(OP_SEARCH, 5, 0);
      send_request(OP_SEARCH, 0, 0);              // match at the tail
      send_request(OP_SEARCH, 1234, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_POP_FRONT, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_POP_BACK, 0, 0);            // removes the last node
      send_request(OP_PUSH_BACK, 9, 0);           // head/tail must be sane again
      send_request(OP_PUSH_FRONT, 3, 0);
      send_request(OP_POP_BACK, 0, 0);
      send_request(OP_SEARCH, 3, 0);
      drain_responses();

      // random phases; the sender waits for a full drain at each boundary
      for (p = 0; p < PHASES; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         for (n = 0; n < PHASE_ITEMS; n++) random_request(phase_grow[p]);
         drain_responses();
      end

      idle_pct  = 0;
      stall_pct = 0;
      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
